@@ sv/dtq_pkg.sv @@
// ----------------------------------------------------------------------------
// dtq_pkg
// shared types and constants of the deadline timer queue
// ----------------------------------------------------------------------------
package dtq_pkg;

   localparam int TimerSlots = 16;
   localparam int SlotBits = $clog2(TimerSlots);
   localparam int CountBits = $clog2(TimerSlots + 1);
   localparam int TimeBits = 40;
   localparam int PeriodBits = 20;
   localparam int TaskBits = 8;
   localparam int RecipBits = 30;

   localparam logic [TimeBits-1:0] TimeMax = {TimeBits{1'b1}};
   localparam logic [PeriodBits-1:0] HourSeconds = PeriodBits'(3600);
   localparam logic [PeriodBits-1:0] DaySeconds = PeriodBits'(24 * 3600);
   localparam logic [PeriodBits-1:0] WeekSeconds = PeriodBits'(7 * 24 * 3600);

   // floor(2^TimeBits / period) for the alignment quotient
   localparam logic [RecipBits-1:0] HourRecip =
      RecipBits'((64'd1 << TimeBits) / 64'd3600);
   localparam logic [RecipBits-1:0] DayRecip =
      RecipBits'((64'd1 << TimeBits) / (64'd24 * 64'd3600));
   localparam logic [RecipBits-1:0] WeekRecip =
      RecipBits'((64'd1 << TimeBits) / (64'd7 * 64'd24 * 64'd3600));

   typedef enum logic [2:0] {
      MODE_CHECK  = 3'd0,
      MODE_AT     = 3'd1,
      MODE_AFTER  = 3'd2,
      MODE_EVERY  = 3'd3,
      MODE_HOURLY = 3'd4,
      MODE_DAILY  = 3'd5,
      MODE_WEEKLY = 3'd6,
      MODE_REMOVE = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      KIND_ONCE     = 2'd0,
      KIND_RELATIVE = 2'd1,
      KIND_ALIGNED  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NONE     = 2'd1,
      STATUS_FULL     = 2'd2,
      STATUS_NO_MATCH = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]            mode;
      logic [TimeBits-1:0]   now_seconds;
      logic [TimeBits-1:0]   deadline_time;
      logic [PeriodBits-1:0] delay_seconds;
      logic [TaskBits-1:0]   task_id;
   } req_type;

   typedef struct packed {
      logic                fired;
      logic [TaskBits-1:0] fired_task;
      logic [1:0]          status;
      logic [4:0]          pending_count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request, clear scan
      logic scan;       // examine one slot
      logic align;      // one alignment step
      logic commit;     // apply the change to the table
      logic finish;     // build result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_last;
      logic align_done;
   } sts_type;

endpackage

@@ sv/dtq_ctrl.sv @@
// ----------------------------------------------------------------------------
// dtq_ctrl
// sequencer: load, slot scan, alignment, commit, respond
// ----------------------------------------------------------------------------
module dtq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  dtq_pkg::sts_type  sts,
   output dtq_pkg::cmd_type  cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SCAN   = 6'b000010,
      ST_ALIGN  = 6'b000100,
      ST_COMMIT = 6'b001000,
      ST_FINISH = 6'b010000,
      ST_OUT    = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_last) state_in = ST_ALIGN;
         end
         ST_ALIGN: begin
            cmd.align = 1'b1;
            if (sts.align_done) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> req_ready)
      else $error("load outside idle");
   a_out_after_finish: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid)
      else $error("result not presented after finish");

endmodule

@@ sv/dtq_datapath.sv @@
// ----------------------------------------------------------------------------
// dtq_datapath
// slot table, per-cycle scan, alignment unit and result register
// ----------------------------------------------------------------------------
module dtq_datapath (
   input  logic              clock,
   input  logic              reset,
   input  dtq_pkg::req_type  req_data,
   input  dtq_pkg::cmd_type  cmd,
   output dtq_pkg::sts_type  sts,
   output dtq_pkg::rsp_type  rsp_data
);

   localparam int SB = dtq_pkg::SlotBits;
   localparam int CB = dtq_pkg::CountBits;
   localparam int TB = dtq_pkg::TimeBits;
   localparam int PB = dtq_pkg::PeriodBits;
   localparam int KB = dtq_pkg::TaskBits;
   localparam int NS = dtq_pkg::TimerSlots;
   localparam int RB = dtq_pkg::RecipBits;

   logic [NS-1:0]  valid_ff;
   logic [TB-1:0]  dl_mem  [NS];
   logic [PB-1:0]  per_mem [NS];
   logic [1:0]     kind_mem[NS];
   logic [KB-1:0]  task_mem[NS];
   logic [CB-1:0]  ord_mem [NS];
   logic [CB-1:0]  count_ff;

   dtq_pkg::req_type req_ff;
   logic [SB-1:0]  idx_ff;
   logic           found_ff;
   logic [SB-1:0]  best_ff;
   logic [TB-1:0]  best_dl_ff;
   logic [CB-1:0]  best_ord_ff;
   logic           free_found_ff;
   logic [SB-1:0]  free_ff;
   logic [TB-1:0]  ins_dl_ff;
   logic [PB-1:0]  ins_per_ff;
   logic [1:0]     ins_kind_ff;
   logic [KB-1:0]  ins_task_ff;
   logic           aligned_mode;
   logic           align_step;
   dtq_pkg::rsp_type rsp_ff;
   logic           fire_ff;
   logic [1:0]     st_ff;

   logic [2:0]          aln_ff;
   logic [TB-1:0]       diff;
   logic [RB-1:0]       recip;
   logic [PB+RB-1:0]    prod_lo_ff;
   logic [TB-PB+RB-1:0] prod_hi_ff;
   logic [TB+RB-1:0]    prod_sum;
   logic [RB-1:0]       quot_ff;
   logic [2*PB:0]       qp;
   logic [PB:0]         rem_ff;
   logic [PB:0]         rem_fix;
   logic [PB-1:0]       pad_ff;

   logic           is_check, is_remove, hit;
   logic [TB-1:0]  cur_dl;
   logic [CB-1:0]  cur_ord;

   assign is_check  = (req_ff.mode == dtq_pkg::MODE_CHECK);
   assign is_remove = (req_ff.mode == dtq_pkg::MODE_REMOVE);
   assign cur_dl  = dl_mem[idx_ff];
   assign cur_ord = ord_mem[idx_ff];
   assign sts.scan_last = (idx_ff == SB'(NS - 1));

   // candidate selection for the slot under the scan pointer
   always_comb begin
      hit = 1'b0;
      if (valid_ff[idx_ff]) begin
         if (is_check)
            hit = !found_ff || cur_dl < best_dl_ff ||
                  (cur_dl == best_dl_ff && cur_ord < best_ord_ff);
         else if (is_remove)
            hit = cur_dl == req_ff.deadline_time &&
                  (!found_ff || cur_ord < best_ord_ff);
      end
   end

   function automatic logic [TB-1:0] sat_add(input logic [TB-1:0] a,
                                             input logic [PB-1:0] b);
      logic [TB:0] s;
      s = {1'b0, a} + {{(TB + 1 - PB){1'b0}}, b};
      return s[TB] ? dtq_pkg::TimeMax : s[TB-1:0];
   endfunction

   // aligned start in the past: now plus the distance to the next period boundary
   // quotient by reciprocal multiply, then remainder with one correction
   assign aligned_mode = (req_ff.mode == dtq_pkg::MODE_HOURLY) ||
                         (req_ff.mode == dtq_pkg::MODE_DAILY) ||
                         (req_ff.mode == dtq_pkg::MODE_WEEKLY);
   assign align_step = aligned_mode && ins_dl_ff < req_ff.now_seconds;
   assign sts.align_done = !align_step || aln_ff == 3'd4;

   always_comb begin
      unique case (req_ff.mode)
         dtq_pkg::MODE_HOURLY: recip = dtq_pkg::HourRecip;
         dtq_pkg::MODE_DAILY:  recip = dtq_pkg::DayRecip;
         default:              recip = dtq_pkg::WeekRecip;
      endcase
   end

   assign diff = req_ff.now_seconds - ins_dl_ff;
   assign prod_sum = {prod_hi_ff, {PB{1'b0}}} + {{(TB - PB){1'b0}}, prod_lo_ff};
   assign qp = quot_ff[PB:0] * ins_per_ff;
   assign rem_fix = (rem_ff >= {1'b0, ins_per_ff}) ? rem_ff - {1'b0, ins_per_ff} : rem_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff   <= req_data;
         idx_ff   <= '0;
         found_ff <= 1'b0;
         free_found_ff <= 1'b0;
         aln_ff   <= '0;
         ins_task_ff <= req_data.task_id;
         unique case (req_data.mode)
            dtq_pkg::MODE_AT: begin
               ins_dl_ff <= req_data.deadline_time; ins_per_ff <= '0;
               ins_kind_ff <= dtq_pkg::KIND_ONCE;
            end
            dtq_pkg::MODE_AFTER: begin
               ins_dl_ff <= sat_add(req_data.now_seconds, req_data.delay_seconds);
               ins_per_ff <= '0; ins_kind_ff <= dtq_pkg::KIND_ONCE;
            end
            dtq_pkg::MODE_EVERY: begin
               ins_dl_ff <= sat_add(req_data.now_seconds, req_data.delay_seconds);
               ins_per_ff <= req_data.delay_seconds;
               ins_kind_ff <= dtq_pkg::KIND_RELATIVE;
            end
            dtq_pkg::MODE_HOURLY: begin
               ins_dl_ff <= req_data.deadline_time; ins_per_ff <= dtq_pkg::HourSeconds;
               ins_kind_ff <= dtq_pkg::KIND_ALIGNED;
            end
            dtq_pkg::MODE_DAILY: begin
               ins_dl_ff <= req_data.deadline_time; ins_per_ff <= dtq_pkg::DaySeconds;
               ins_kind_ff <= dtq_pkg::KIND_ALIGNED;
            end
            dtq_pkg::MODE_WEEKLY: begin
               ins_dl_ff <= req_data.deadline_time; ins_per_ff <= dtq_pkg::WeekSeconds;
               ins_kind_ff <= dtq_pkg::KIND_ALIGNED;
            end
            default: begin
               ins_dl_ff <= req_data.deadline_time; ins_per_ff <= '0;
               ins_kind_ff <= dtq_pkg::KIND_ONCE;
            end
         endcase
      end else if (cmd.scan) begin
         idx_ff <= idx_ff + SB'(1);
         if (hit) begin
            found_ff    <= 1'b1;
            best_ff     <= idx_ff;
            best_dl_ff  <= cur_dl;
            best_ord_ff <= cur_ord;
         end
         if (!valid_ff[idx_ff] && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_ff <= idx_ff;
         end
      end else if (cmd.align) begin
         if (align_step) begin
            aln_ff <= aln_ff + 3'd1;
            unique case (aln_ff)
               3'd0: begin
                  prod_lo_ff <= diff[PB-1:0] * recip;
                  prod_hi_ff <= diff[TB-1:PB] * recip;
               end
               3'd1: quot_ff <= prod_sum[TB+RB-1:TB];
               3'd2: rem_ff <= diff[PB:0] - qp[PB:0];
               3'd3: pad_ff <= (rem_fix == '0) ? '0 : ins_per_ff - rem_fix[PB-1:0];
               default: ins_dl_ff <= sat_add(req_ff.now_seconds, pad_ff);
            endcase
         end
      end
   end

   // table update
   logic do_fire, do_drop, do_ins;
   logic [SB-1:0] ins_slot;
   logic [TB-1:0] re_dl;
   logic [1:0]    bkind;
   logic [NS-1:0] valid_in;

   assign bkind   = kind_mem[best_ff];
   assign do_fire = is_check && found_ff && best_dl_ff <= req_ff.now_seconds;
   assign do_drop = do_fire || (is_remove && found_ff);
   assign do_ins  = (do_fire && bkind != dtq_pkg::KIND_ONCE) ||
                    (!is_check && !is_remove && free_found_ff);
   // re-arm reuses the freed slot when no lower free slot exists
   assign ins_slot = (do_fire && !(free_found_ff && free_ff < best_ff)) ? best_ff : free_ff;
   assign re_dl = (bkind == dtq_pkg::KIND_RELATIVE) ?
                  sat_add(req_ff.now_seconds, per_mem[best_ff]) :
                  sat_add(best_dl_ff, per_mem[best_ff]);

   always_comb begin
      valid_in = valid_ff;
      if (do_drop) valid_in[best_ff] = 1'b0;
      if (do_ins) valid_in[ins_slot] = 1'b1;
   end

   logic [CB-1:0] cnt_drop;
   assign cnt_drop = do_drop ? count_ff - CB'(1) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else if (cmd.commit) begin
         for (int i = 0; i < NS; i++)
            if (do_drop && valid_ff[i] && ord_mem[i] > best_ord_ff)
               ord_mem[i] <= ord_mem[i] - CB'(1);
         valid_ff <= valid_in;
         if (do_ins) begin
            if (do_fire) begin
               dl_mem[ins_slot]   <= re_dl;
               per_mem[ins_slot]  <= per_mem[best_ff];
               kind_mem[ins_slot] <= bkind;
               task_mem[ins_slot] <= task_mem[best_ff];
            end else begin
               dl_mem[ins_slot]   <= ins_dl_ff;
               per_mem[ins_slot]  <= ins_per_ff;
               kind_mem[ins_slot] <= ins_kind_ff;
               task_mem[ins_slot] <= ins_task_ff;
            end
            ord_mem[ins_slot] <= cnt_drop;
         end
         count_ff <= do_ins ? cnt_drop + CB'(1) : cnt_drop;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         fire_ff <= do_fire;
         rsp_ff.fired_task <= do_fire ? task_mem[best_ff] : '0;
         if (is_check) st_ff <= do_fire ? dtq_pkg::STATUS_OK : dtq_pkg::STATUS_NONE;
         else if (is_remove) st_ff <= found_ff ? dtq_pkg::STATUS_OK : dtq_pkg::STATUS_NO_MATCH;
         else st_ff <= free_found_ff ? dtq_pkg::STATUS_OK : dtq_pkg::STATUS_FULL;
      end
      if (cmd.finish) begin
         rsp_ff.fired <= fire_ff;
         rsp_ff.status <= st_ff;
         rsp_ff.pending_count <= 5'(count_ff);
      end
   end

   assign rsp_data.fired = rsp_ff.fired;
   assign rsp_data.fired_task = rsp_ff.fired_task;
   assign rsp_data.status = rsp_ff.status;
   assign rsp_data.pending_count = rsp_ff.pending_count;

   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff == CB'($countones(valid_ff)))
      else $error("count out of step with valid bits");
   a_fire_needs_found: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && do_fire) |-> found_ff)
      else $error("fire without candidate");
   a_ins_slot_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && do_ins && !do_fire) |-> !valid_ff[ins_slot])
      else $error("insert into busy slot");

endmodule

@@ sv/deadline_timer_queue_unit.sv @@
// ----------------------------------------------------------------------------
// deadline_timer_queue_unit
// timer table with earliest-deadline fire, insert, re-arm and remove
// ----------------------------------------------------------------------------
// flow: the accepting edge loads the request, then a scan of all 16 slots, alignment
// (extended for a past aligned start), commit and finish; rsp_valid then holds until rsp_ready
// throughput: one item at a time; a new request is taken only once the response is accepted
// reset: synchronous, clears the valid bits, live count and controller state
module deadline_timer_queue_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dtq_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dtq_pkg::rsp_type  rsp_data
);

   dtq_pkg::cmd_type cmd;
   dtq_pkg::sts_type sts;

   dtq_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .sts, .cmd
   );

   dtq_datapath u_dp (
      .clock, .reset, .req_data, .cmd, .sts, .rsp_data
   );

endmodule
